FILE: hdl/circular_byte_buffer_unit_macros.svh
// Assertion shorthands used by the checker file.
`ifndef CIRCULAR_BYTE_BUFFER_UNIT_MACROS_SVH
`define CIRCULAR_BYTE_BUFFER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CBB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/cbb_pkg.sv
package cbb_pkg;

  localparam int DEF_MAX_DEPTH = 256;
  localparam int DEF_MAX_BURST = 64;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic       is_read;
    logic [7:0] wr_byte;
    logic [6:0] want;
  } cmd_t;

endpackage

FILE: hdl/circular_byte_buffer_unit.sv
// Byte ring buffer. A write item (op 0) yields one acknowledge; a read item
// (op 1) yields one result per byte removed, up to min(rd_count, MAX_BURST,
// fill), or a single result with ok clear when nothing can be read. The back
// end does one byte (or one acknowledge) per cycle through its single memory
// port while the output does not stall; a two-entry command queue in front
// lets input keep flowing meanwhile. An accepted item passes the command
// queue, the current-item register, stage s1 and the output register; the
// registered memory read runs alongside the issue stage. Writing capacity
// empties the buffer; do it only while idle. cfg_ready is always high.
module circular_byte_buffer_unit #(
  parameter int MAX_DEPTH = cbb_pkg::DEF_MAX_DEPTH,
  parameter int MAX_BURST = cbb_pkg::DEF_MAX_BURST
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] capacity,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] wr_byte,
  input  logic [6:0] rd_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       kind,
  output logic       ok,
  output logic [7:0] data_byte,
  output logic       last,
  output logic [8:0] fill_level,
  output logic [8:0] free_space,
  output logic       empty_res
);

  logic          q_valid;
  logic          q_pop;
  cbb_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  cbb_front #(
    .MAX_BURST(MAX_BURST)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op      (op),
    .wr_byte (wr_byte),
    .rd_count(rd_count),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_cmd   (q_cmd)
  );

  cbb_back #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .capacity  (capacity),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .ok        (ok),
    .data_byte (data_byte),
    .last      (last),
    .fill_level(fill_level),
    .free_space(free_space),
    .empty_res (empty_res)
  );

endmodule

FILE: hdl/cbb_front.sv
module cbb_front #(
  parameter int MAX_BURST = cbb_pkg::DEF_MAX_BURST
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          op,
  input  logic [7:0]    wr_byte,
  input  logic [6:0]    rd_count,
  output logic          q_valid,
  input  logic          q_pop,
  output cbb_pkg::cmd_t q_cmd
);

  cbb_pkg::cmd_t cmd_in;
  cbb_pkg::cmd_t slots [2];
  logic          wr_sel;
  logic          rd_sel;
  logic [1:0]    q_cnt;
  logic          push;
  logic          pop;

  // classify and clamp the request size
  always_comb begin
    cmd_in.is_read = (op == cbb_pkg::OP_READ);
    cmd_in.wr_byte = wr_byte;
    cmd_in.want    = (rd_count > 7'(MAX_BURST)) ? 7'(MAX_BURST) : rd_count;
  end

  assign in_stall = (q_cnt == 2'd2);
  assign q_valid  = (q_cnt != 2'd0);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_cmd    = slots[rd_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) wr_sel <= ~wr_sel;
      if (pop)  rd_sel <= ~rd_sel;
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_sel] <= cmd_in;
  end

endmodule

FILE: hdl/cbb_back.sv
module cbb_back #(
  parameter int MAX_DEPTH = cbb_pkg::DEF_MAX_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [8:0]    capacity,
  input  logic          q_valid,
  output logic          q_pop,
  input  cbb_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          kind,
  output logic          ok,
  output logic [7:0]    data_byte,
  output logic          last,
  output logic [8:0]    fill_level,
  output logic [8:0]    free_space,
  output logic          empty_res
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(MAX_DEPTH + 1);

  logic [7:0]    mem [MAX_DEPTH];
  logic [7:0]    mem_q;

  logic [CW-1:0] cap_reg;
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [CW-1:0] cnt;
  logic [31:0]   cap_in;
  logic [31:0]   cap_sat;

  logic          cur_v;
  cbb_pkg::cmd_t cur;
  logic          cur_first;

  logic          s1_v;
  logic          s1_kind;
  logic          s1_ok;
  logic          s1_last;
  logic [8:0]    s1_fill;
  logic [8:0]    s1_free;
  logic          s1_empty;

  logic          out_load;
  logic          s1_adv;
  logic          issue;
  logic          done;
  logic          cur_ld;
  logic          mem_we;
  logic          mem_re;
  logic          res_ok;
  logic          res_last;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] wp_inc;
  logic [CW-1:0] rp_inc;
  logic [AW-1:0] wp_next;
  logic [AW-1:0] rp_next;
  logic [CW+8:0] fill_ext;
  logic [CW+8:0] free_ext;

  assign out_load = !out_valid || !out_stall;
  assign s1_adv   = s1_v && out_load;
  assign issue    = cur_v && (!s1_v || out_load);
  assign cur_ld   = q_valid && (!cur_v || (issue && done));
  assign q_pop    = cur_ld;

  assign wp_inc  = CW'(wp) + CW'(1);
  assign rp_inc  = CW'(rp) + CW'(1);
  assign wp_next = (wp_inc >= cap_reg) ? '0 : wp_inc[AW-1:0];
  assign rp_next = (rp_inc >= cap_reg) ? '0 : rp_inc[AW-1:0];

  assign cap_in  = {23'd0, capacity};
  assign cap_sat = (cap_in == 32'd0) ? 32'd1 :
                   (cap_in > 32'(MAX_DEPTH)) ? 32'(MAX_DEPTH) : cap_in;

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    done     = 1'b0;
    res_ok   = 1'b0;
    res_last = 1'b0;
    cnt_next = cnt;
    if (issue) begin
      priority if (!cur.is_read) begin
        done     = 1'b1;
        res_last = 1'b1;
        if (cnt < cap_reg) begin
          mem_we   = 1'b1;
          res_ok   = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end else if (cur_first && (cur.want == 7'd0 || cnt == '0)) begin
        done     = 1'b1;
        res_last = 1'b1;
      end else begin
        mem_re   = 1'b1;
        res_ok   = 1'b1;
        cnt_next = cnt - CW'(1);
        res_last = (cur.want == 7'd1) || (cnt == CW'(1));
        done     = res_last;
      end
    end
  end

  assign fill_ext = {9'd0, cnt_next};
  assign free_ext = {9'd0, cap_reg - cnt_next};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wp] <= cur.wr_byte;
    if (mem_re) mem_q <= mem[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg   <= CW'(MAX_DEPTH);
      wp        <= '0;
      rp        <= '0;
      cnt       <= '0;
      cur_v     <= 1'b0;
      s1_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_reg <= cap_sat[CW-1:0];
        wp      <= '0;
        rp      <= '0;
        cnt     <= '0;
      end else begin
        if (mem_we) wp <= wp_next;
        if (mem_re) rp <= rp_next;
        cnt <= cnt_next;
      end
      if (cur_ld) begin
        cur_v <= 1'b1;
      end else if (issue && done) begin
        cur_v <= 1'b0;
      end
      if (issue) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cur_ld) begin
      cur       <= q_cmd;
      cur_first <= 1'b1;
    end else if (issue) begin
      cur_first <= 1'b0;
      cur.want  <= cur.want - 7'd1;
    end
    if (issue) begin
      s1_kind  <= cur.is_read ? cbb_pkg::KIND_READ : cbb_pkg::KIND_ACK;
      s1_ok    <= res_ok;
      s1_last  <= res_last;
      s1_fill  <= fill_ext[8:0];
      s1_free  <= free_ext[8:0];
      s1_empty <= (cnt_next == '0);
    end
    if (s1_adv) begin
      kind       <= s1_kind;
      ok         <= s1_ok;
      data_byte  <= (s1_kind == cbb_pkg::KIND_READ && s1_ok) ? mem_q : 8'd0;
      last       <= s1_last;
      fill_level <= s1_fill;
      free_space <= s1_free;
      empty_res  <= s1_empty;
    end
  end

endmodule

FILE: hdl/cbb_checker.sv
`include "circular_byte_buffer_unit_macros.svh"

module cbb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       kind,
  input logic       ok,
  input logic [7:0] data_byte,
  input logic       last
);

  `CBB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(last), "stalled result changed")
  `CBB_ASSERT_NOW(a_ack_last, out_valid && kind == cbb_pkg::KIND_ACK, last, "write ack without last")
  `CBB_ASSERT_NOW(a_fail_zero, out_valid && !ok, data_byte == 8'd0 && last, "failed result not zero/last")
  `CBB_ASSERT_NEXT(a_burst_cont, out_valid && !out_stall && kind == cbb_pkg::KIND_READ && !last, !(out_valid && kind == cbb_pkg::KIND_ACK), "burst cut by ack")

endmodule

bind circular_byte_buffer_unit cbb_checker u_cbb_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic       kind;
    logic       ok;
    logic [7:0] data_byte;
    logic       last;
    logic [8:0] fill_level;
    logic [8:0] free_space;
    logic       empty_res;
  } ring_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [8:0] capacity = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       op = cbb_pkg::OP_WRITE;
  logic [7:0] wr_byte = '0;
  logic [6:0] rd_count = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic       ok;
  logic [7:0] data_byte;
  logic       last;
  logic [8:0] fill_level;
  logic [8:0] free_space;
  logic       empty_res;

  circular_byte_buffer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .capacity  (capacity),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .wr_byte   (wr_byte),
    .rd_count  (rd_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .ok        (ok),
    .data_byte (data_byte),
    .last      (last),
    .fill_level(fill_level),
    .free_space(free_space),
    .empty_res (empty_res)
  );

  always #1 clk = ~clk;

  // ring model
  logic [7:0]  ring_mem [cbb_pkg::DEF_MAX_DEPTH];
  int unsigned rd_ptr = 0;
  int unsigned wr_ptr = 0;
  int unsigned held_bytes = 0;
  int unsigned ring_cap = cbb_pkg::DEF_MAX_DEPTH;

  cbb_pkg::cmd_t pending_q [$];
  ring_result_t  expected_q [$];
  cbb_pkg::cmd_t cur_cmd;
  ring_result_t  got_res;
  ring_result_t  exp_res;

  int  items_queued = 0;
  int  items_accepted = 0;
  int  fail_count = 0;
  int  send_wait = 0;
  int  recv_wait = 0;
  int  hold_left = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  bit  send_eager = 1'b0;
  bit  recv_eager = 1'b0;
  bit  next_in_valid;

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= ring_cap) ? 0 : idx + 1;
  endfunction

  function automatic void push_result(logic k, logic good, logic [7:0] d, logic lst);
    ring_result_t r;
    r.kind       = k;
    r.ok         = good;
    r.data_byte  = d;
    r.last       = lst;
    r.fill_level = held_bytes[8:0];
    r.free_space = 9'(ring_cap - held_bytes);
    r.empty_res  = (held_bytes == 0);
    expected_q.push_back(r);
  endfunction

  function automatic void set_capacity(logic [8:0] v);
    if (v == 0)
      ring_cap = 1;
    else if (v > cbb_pkg::DEF_MAX_DEPTH)
      ring_cap = cbb_pkg::DEF_MAX_DEPTH;
    else
      ring_cap = v;
    rd_ptr = 0;
    wr_ptr = 0;
    held_bytes = 0;
  endfunction

  function automatic void predict_item(cbb_pkg::cmd_t c);
    int unsigned want_n;
    int unsigned take_n;
    logic [7:0]  b;
    if (c.is_read == cbb_pkg::OP_WRITE) begin
      if (held_bytes < ring_cap) begin
        ring_mem[wr_ptr] = c.wr_byte;
        wr_ptr = ring_next(wr_ptr);
        held_bytes++;
        push_result(cbb_pkg::KIND_ACK, 1'b1, 8'h00, 1'b1);
      end else begin
        push_result(cbb_pkg::KIND_ACK, 1'b0, 8'h00, 1'b1);
      end
    end else begin
      want_n = (c.want > cbb_pkg::DEF_MAX_BURST) ? cbb_pkg::DEF_MAX_BURST : c.want;
      take_n = (want_n < held_bytes) ? want_n : held_bytes;
      if (take_n == 0) begin
        push_result(cbb_pkg::KIND_READ, 1'b0, 8'h00, 1'b1);
      end else begin
        for (int unsigned i = 0; i < take_n; i++) begin
          b = ring_mem[rd_ptr];
          rd_ptr = ring_next(rd_ptr);
          held_bytes--;
          push_result(cbb_pkg::KIND_READ, 1'b1, b, (i + 1 == take_n));
        end
      end
    end
  endfunction

  function automatic int draw_gap(bit eager);
    return eager ? 0 : int'($urandom_range(0, 17));
  endfunction

  task automatic check_field(input string name, input logic [8:0] expv,
                             input logic [8:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      fail_count++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      next_in_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_item(cur_cmd);
        items_accepted++;
        next_in_valid = 1'b0;
        send_wait = draw_gap(send_eager);
      end
      if (!next_in_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_q.size() > 0) begin
          cur_cmd = pending_q.pop_front();
          op <= cur_cmd.is_read;
          wr_byte <= cur_cmd.wr_byte;
          rd_count <= cur_cmd.want;
          next_in_valid = 1'b1;
        end
      end
      in_valid <= next_in_valid;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_res = '{kind, ok, data_byte, last, fill_level, free_space, empty_res};
        if (expected_q.size() == 0) begin
          $error("unexpected result item: kind %0d data_byte %0d", kind, data_byte);
          fail_count++;
        end else begin
          exp_res = expected_q.pop_front();
          check_field("kind", exp_res.kind, got_res.kind);
          check_field("ok", exp_res.ok, got_res.ok);
          check_field("data_byte", exp_res.data_byte, got_res.data_byte);
          check_field("last", exp_res.last, got_res.last);
          check_field("fill_level", exp_res.fill_level, got_res.fill_level);
          check_field("free_space", exp_res.free_space, got_res.free_space);
          check_field("empty_res", exp_res.empty_res, got_res.empty_res);
        end
        recv_wait = draw_gap(recv_eager);
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_item(input logic is_rd, input logic [7:0] b, input logic [6:0] n);
    cbb_pkg::cmd_t c;
    c.is_read = is_rd;
    c.wr_byte = b;
    c.want    = n;
    pending_q.push_back(c);
    items_queued++;
  endtask

  task automatic queue_random(input int n, input int write_pct);
    logic [6:0] cnt;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < write_pct) begin
        queue_item(cbb_pkg::OP_WRITE, 8'($urandom), 7'($urandom));
      end else begin
        if ($urandom_range(0, 7) == 0)
          cnt = 7'($urandom_range(0, 127));
        else
          cnt = 7'($urandom_range(1, cbb_pkg::DEF_MAX_BURST));
        queue_item(cbb_pkg::OP_READ, 8'($urandom), cnt);
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (items_accepted != items_queued || expected_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [8:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    capacity <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_capacity(v);
  endtask

  initial begin
    logic [8:0] cap_list [$];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default capacity: empty reads, zero-length read, burst saturation
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd5);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd0);
    queue_item(cbb_pkg::OP_WRITE, 8'h00, 7'd0);
    queue_item(cbb_pkg::OP_WRITE, 8'hFF, 7'd127);
    queue_item(cbb_pkg::OP_WRITE, 8'hA5, 7'd0);
    queue_item(cbb_pkg::OP_WRITE, 8'h5A, 7'd0);
    queue_item(cbb_pkg::OP_READ, 8'hFF, 7'd127);
    queue_item(cbb_pkg::OP_WRITE, 8'h3C, 7'd0);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd64);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd1);
    drain();

    // single-byte ring: full rejection, zero-length read with data held
    write_capacity(9'd1);
    queue_item(cbb_pkg::OP_WRITE, 8'h11, 7'd0);
    queue_item(cbb_pkg::OP_WRITE, 8'h22, 7'd0);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd0);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd2);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd1);
    drain();

    write_capacity(9'd0);
    queue_item(cbb_pkg::OP_WRITE, 8'hC3, 7'd0);
    queue_item(cbb_pkg::OP_WRITE, 8'h7E, 7'd0);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd64);
    drain();

    write_capacity(9'd511);
    queue_item(cbb_pkg::OP_WRITE, 8'h01, 7'd0);
    queue_item(cbb_pkg::OP_WRITE, 8'h80, 7'd0);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd1);
    queue_item(cbb_pkg::OP_READ, 8'h00, 7'd1);
    drain();

    cap_list = '{9'd2, 9'd3, 9'd5, 9'd17, 9'd64, 9'd255, 9'd256, 9'd257,
                 9'($urandom_range(1, 511)), 9'd4, 9'd1};
    foreach (cap_list[k]) begin
      send_eager = ($urandom_range(0, 2) == 0);
      recv_eager = ($urandom_range(0, 2) == 0);
      write_capacity(cap_list[k]);
      queue_random(16, 50 + 10 * (k % 4));
      if (k == 4) begin
        // sender waits for the block to go quiet mid-phase
        drain();
      end
      queue_random(17, 50 + 10 * (k % 4));
      drain();
    end

    // receiver holds off long while the sender keeps offering items
    send_eager = 1'b1;
    recv_eager = 1'b0;
    write_capacity(9'd64);
    hold_requests++;
    queue_random(30, 70);
    drain();

    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
